// ===== rtl/pst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Shared widths, codes and beat types of the polyline stroke triangulator.
// ----------------------------------------------------------------------------
package pst_pkg;

    // Field widths
    localparam int COORD_W    = 20;            // Q16.4 coordinates
    localparam int SUM_W      = COORD_W + 1;   // endpoint plus offset before saturation
    localparam int NRM_W      = 16;            // Q1.14 normal components
    localparam int THICK_W    = 12;            // Q8.4 thickness
    localparam int OFF_W      = 14;            // rounded Q16.4 offsets, +/-4111 at most
    localparam int OUT_IDX_W  = 16;            // index fields of a record
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int INDEX_WIDTH_DEF = 16;

    // Saturation limits
    localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

    // 1.0 pixel in Q8.4
    localparam logic [THICK_W-1:0] THICK_ONE = 12'd16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BASE = 1'd1;

    // Record kinds
    localparam logic RK_VERTEX   = 1'b0;
    localparam logic RK_TRIANGLE = 1'b1;

    // One segment beat
    typedef struct packed {
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] next_x;
        logic signed [COORD_W-1:0] next_y;
        logic signed [NRM_W-1:0]   normal_x;
        logic signed [NRM_W-1:0]   normal_y;
        logic                      first_of_contour;
        logic                      last_of_contour;
    } t_seg;

    // One record beat
    typedef struct packed {
        logic                      record_kind;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic                      fringe_flag;
        logic [OUT_IDX_W-1:0]      index_a;
        logic [OUT_IDX_W-1:0]      index_b;
        logic [OUT_IDX_W-1:0]      index_c;
        logic                      last_record;
    } t_rec;

endpackage

// ===== rtl/pst_seg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_seg_if
// Valid/ready channel carrying one polyline segment per beat.
// ----------------------------------------------------------------------------
interface pst_seg_if;
    import pst_pkg::*;

    logic valid;
    logic ready;
    t_seg data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pst_rec_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_rec_if
// Valid/ready channel carrying one vertex or triangle record per beat.
// ----------------------------------------------------------------------------
interface pst_rec_if;
    import pst_pkg::*;

    logic valid;
    logic ready;
    t_rec data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pst_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_offset
// Body and fringe offsets of one normal component:
// round(n * (T -/+ 16) / 2^15), halves rounded up.
// ----------------------------------------------------------------------------
module pst_offset (
    input  logic signed [pst_pkg::NRM_W-1:0]   i_norm,
    input  logic        [pst_pkg::THICK_W-1:0] i_thick,
    output logic signed [pst_pkg::OFF_W-1:0]   o_body,
    output logic signed [pst_pkg::OFF_W-1:0]   o_fringe
);
    import pst_pkg::*;

    localparam int FAC_W  = THICK_W + 2;
    localparam int PROD_W = NRM_W + FAC_W;
    localparam int SHIFT  = 15;

    logic signed [FAC_W-1:0]  w_fac_body;
    logic signed [FAC_W-1:0]  w_fac_fringe;
    logic signed [PROD_W-1:0] w_prod_body;
    logic signed [PROD_W-1:0] w_prod_fringe;
    logic signed [PROD_W-1:0] w_rnd_body;
    logic signed [PROD_W-1:0] w_rnd_fringe;

    // T - 1.0 px and T + 1.0 px
    assign w_fac_body   = $signed({2'b00, i_thick}) - $signed(FAC_W'(THICK_ONE));
    assign w_fac_fringe = $signed({2'b00, i_thick}) + $signed(FAC_W'(THICK_ONE));

    assign w_prod_body   = PROD_W'(i_norm) * PROD_W'(w_fac_body);
    assign w_prod_fringe = PROD_W'(i_norm) * PROD_W'(w_fac_fringe);

    // add half an LSB, then floor by dropping the low bits
    assign w_rnd_body   = w_prod_body   + $signed(PROD_W'(1) << (SHIFT - 1));
    assign w_rnd_fringe = w_prod_fringe + $signed(PROD_W'(1) << (SHIFT - 1));

    assign o_body   = w_rnd_body[OFF_W+SHIFT-1:SHIFT];
    assign o_fringe = w_rnd_fringe[OFF_W+SHIFT-1:SHIFT];
endmodule

// ===== rtl/polyline_stroke_triangulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_triangulator_top
// Turns each closed-contour segment into eight offset vertices, the body and
// fringe triangles, and join or closing triangles where the contour needs them.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        beat
//  i_seg     in   valid/ready      one segment (endpoints, normal, flags)
//  o_rec     out  valid/ready      one vertex or triangle record
//  i_cfg_*   in   write enable     thickness / index base register write
//
//  A segment emits 14 to 22 records, one per cycle while o_rec.ready is high,
//  so the output port sets the rate: 14 records + 4 (join) + 4 (close).
//  Records pass input register, work stage and output register; a new segment is
//  taken while the previous one's records drain (input register + work stage).
//  Segments with thickness below 1.0 px are taken and dropped.
//  Reset (synchronous, active low) empties all stages and clears contour state.
//  A stall on o_rec holds the record; the input register fills, then stalls.
// ----------------------------------------------------------------------------
module polyline_stroke_triangulator_top #(
    parameter int INDEX_WIDTH = pst_pkg::INDEX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [pst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pst_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    pst_seg_if.sink                          i_seg,
    pst_rec_if.source                        o_rec
);
    import pst_pkg::*;

    localparam int STEP_W = 5;
    localparam int IW     = INDEX_WIDTH;

    // record sequence: vertices, join, body, closing triangles
    localparam logic [STEP_W-1:0] STEP_V0 = 5'd0;
    localparam logic [STEP_W-1:0] STEP_V1 = 5'd1;
    localparam logic [STEP_W-1:0] STEP_V2 = 5'd2;
    localparam logic [STEP_W-1:0] STEP_V3 = 5'd3;
    localparam logic [STEP_W-1:0] STEP_V4 = 5'd4;
    localparam logic [STEP_W-1:0] STEP_V5 = 5'd5;
    localparam logic [STEP_W-1:0] STEP_V6 = 5'd6;
    localparam logic [STEP_W-1:0] STEP_V7 = 5'd7;
    localparam logic [STEP_W-1:0] STEP_J0 = 5'd8;
    localparam logic [STEP_W-1:0] STEP_J1 = 5'd9;
    localparam logic [STEP_W-1:0] STEP_J2 = 5'd10;
    localparam logic [STEP_W-1:0] STEP_J3 = 5'd11;
    localparam logic [STEP_W-1:0] STEP_B0 = 5'd12;
    localparam logic [STEP_W-1:0] STEP_B1 = 5'd13;
    localparam logic [STEP_W-1:0] STEP_B2 = 5'd14;
    localparam logic [STEP_W-1:0] STEP_B3 = 5'd15;
    localparam logic [STEP_W-1:0] STEP_B4 = 5'd16;
    localparam logic [STEP_W-1:0] STEP_B5 = 5'd17;
    localparam logic [STEP_W-1:0] STEP_C0 = 5'd18;
    localparam logic [STEP_W-1:0] STEP_C1 = 5'd19;
    localparam logic [STEP_W-1:0] STEP_C2 = 5'd20;
    localparam logic [STEP_W-1:0] STEP_C3 = 5'd21;

    function automatic logic [OUT_IDX_W-1:0] f_out_idx(input logic [IW-1:0] v);
        return OUT_IDX_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // Configuration and contour state
    // ------------------------------------------------------------------
    logic [THICK_W-1:0] r_thick;
    logic [IW-1:0]      r_vcnt;
    logic               r_has_prev;
    logic [IW-1:0]      r_prev_rt, r_prev_rb, r_prev_rft;
    logic [IW-1:0]      r_first_lt, r_first_lb, r_first_lft;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic r_iv;
    t_seg r_in;

    // ------------------------------------------------------------------
    // Work stage: one segment being serialized
    // ------------------------------------------------------------------
    logic                     r_wv;
    logic [STEP_W-1:0]        r_step;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_nx, r_ny;
    logic signed [OFF_W-1:0]  r_bx, r_by, r_fx, r_fy;
    logic [IW-1:0]            r_base;
    logic                     r_hp, r_last;
    logic [IW-1:0]            r_j_rt, r_j_rb, r_j_rft;
    logic [IW-1:0]            r_c_lt, r_c_lb, r_c_lft;

    // Output register
    logic r_ov;
    t_rec r_out;

    logic                    w_thin, w_load, w_take, w_adv, w_last_rec, w_hp_eff;
    logic [STEP_W-1:0]       n_step;
    logic signed [OFF_W-1:0] w_bx, w_by, w_fx, w_fy;
    logic [IW-1:0]           w_id [8];
    t_rec                    w_rec;

    // offsets from the input register
    pst_offset u_off_x (
        .i_norm   (r_in.normal_x),
        .i_thick  (r_thick),
        .o_body   (w_bx),
        .o_fringe (w_fx)
    );

    pst_offset u_off_y (
        .i_norm   (r_in.normal_y),
        .i_thick  (r_thick),
        .o_body   (w_by),
        .o_fringe (w_fy)
    );

    // handshakes between stages
    assign w_adv       = r_wv && (!r_ov || o_rec.ready);
    assign w_last_rec  = (r_step == STEP_C3) || ((r_step == STEP_B5) && !r_last);
    assign w_load      = r_iv && (!r_wv || (w_adv && w_last_rec));
    assign w_thin      = (r_thick < THICK_ONE);
    assign w_take      = w_load && !w_thin;
    assign w_hp_eff    = r_has_prev && !r_in.first_of_contour;
    assign i_seg.ready = !r_iv || w_load;

    // skip the join triangles on a contour's first segment
    always_comb begin
        if ((r_step == STEP_V7) && !r_hp) begin
            n_step = STEP_B0;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_seg.valid && i_seg.ready) begin
            r_iv <= 1'b1;
        end else if (w_load) begin
            r_iv <= 1'b0;
        end
        if (i_seg.valid && i_seg.ready) begin
            r_in <= i_seg.data;
        end
    end

    // configuration writes and contour bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thick     <= THICK_ONE;
            r_vcnt      <= '0;
            r_has_prev  <= 1'b0;
            r_prev_rt   <= '0;
            r_prev_rb   <= '0;
            r_prev_rft  <= '0;
            r_first_lt  <= '0;
            r_first_lb  <= '0;
            r_first_lft <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_THICKNESS: begin
                    r_thick <= i_cfg_wr_data[THICK_W-1:0];
                end
                CFG_INDEX_BASE: begin
                    r_vcnt <= IW'(i_cfg_wr_data);
                end
                default: begin
                end
            endcase
        end else if (w_take) begin
            r_vcnt     <= r_vcnt + IW'(8);
            r_has_prev <= !r_in.last_of_contour;
            r_prev_rt  <= r_vcnt + IW'(4);
            r_prev_rb  <= r_vcnt + IW'(5);
            r_prev_rft <= r_vcnt + IW'(6);
            if (!w_hp_eff) begin
                r_first_lft <= r_vcnt;
                r_first_lt  <= r_vcnt + IW'(2);
                r_first_lb  <= r_vcnt + IW'(3);
            end
        end
    end

    // work stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv   <= 1'b0;
            r_step <= STEP_V0;
        end else if (w_take) begin
            r_wv   <= 1'b1;
            r_step <= STEP_V0;
        end else if (w_adv && w_last_rec) begin
            r_wv <= 1'b0;
        end else if (w_adv) begin
            r_step <= n_step;
        end
        if (w_take) begin
            r_cx    <= r_in.cur_x;
            r_cy    <= r_in.cur_y;
            r_nx    <= r_in.next_x;
            r_ny    <= r_in.next_y;
            r_bx    <= w_bx;
            r_by    <= w_by;
            r_fx    <= w_fx;
            r_fy    <= w_fy;
            r_base  <= r_vcnt;
            r_hp    <= w_hp_eff;
            r_last  <= r_in.last_of_contour;
            r_j_rt  <= r_prev_rt;
            r_j_rb  <= r_prev_rb;
            r_j_rft <= r_prev_rft;
            r_c_lft <= w_hp_eff ? r_first_lft : r_vcnt;
            r_c_lt  <= w_hp_eff ? r_first_lt  : r_vcnt + IW'(2);
            r_c_lb  <= w_hp_eff ? r_first_lb  : r_vcnt + IW'(3);
        end
    end

    // vertex indices of the segment in flight
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_id[k] = r_base + IW'(k);
        end
    end

    // record for the current step
    always_comb begin
        logic                      is_vert, use_next, use_fringe, neg, fringe;
        logic [IW-1:0]             a, b, c;
        logic signed [COORD_W-1:0] px, py;
        logic signed [OFF_W-1:0]   ox, oy;
        logic signed [SUM_W-1:0]   sx, sy;
        is_vert    = 1'b0;
        use_next   = 1'b0;
        use_fringe = 1'b0;
        neg        = 1'b0;
        fringe     = 1'b0;
        a          = '0;
        b          = '0;
        c          = '0;
        case (r_step)
            STEP_V0: begin
                is_vert = 1'b1; use_fringe = 1'b1; fringe = 1'b1; a = w_id[0];
            end
            STEP_V1: begin
                is_vert = 1'b1; use_fringe = 1'b1; neg = 1'b1; fringe = 1'b1; a = w_id[1];
            end
            STEP_V2: begin
                is_vert = 1'b1; a = w_id[2];
            end
            STEP_V3: begin
                is_vert = 1'b1; neg = 1'b1; a = w_id[3];
            end
            STEP_V4: begin
                is_vert = 1'b1; use_next = 1'b1; a = w_id[4];
            end
            STEP_V5: begin
                is_vert = 1'b1; use_next = 1'b1; neg = 1'b1; a = w_id[5];
            end
            STEP_V6: begin
                is_vert = 1'b1; use_next = 1'b1; use_fringe = 1'b1; fringe = 1'b1;
                a = w_id[6];
            end
            STEP_V7: begin
                is_vert = 1'b1; use_next = 1'b1; use_fringe = 1'b1; neg = 1'b1;
                fringe = 1'b1; a = w_id[7];
            end
            // join to the previous segment
            STEP_J0: begin
                fringe = 1'b1; a = r_j_rft; b = w_id[2]; c = r_j_rt;
            end
            STEP_J1: begin
                fringe = 1'b1; a = r_j_rft; b = w_id[0]; c = w_id[2];
            end
            STEP_J2: begin
                a = r_j_rt; b = r_j_rb; c = w_id[3];
            end
            STEP_J3: begin
                a = r_j_rt; b = w_id[3]; c = w_id[2];
            end
            // body and fringes
            STEP_B0: begin
                fringe = 1'b1; a = w_id[0]; b = w_id[2]; c = w_id[4];
            end
            STEP_B1: begin
                fringe = 1'b1; a = w_id[0]; b = w_id[4]; c = w_id[6];
            end
            STEP_B2: begin
                a = w_id[2]; b = w_id[3]; c = w_id[5];
            end
            STEP_B3: begin
                a = w_id[2]; b = w_id[5]; c = w_id[4];
            end
            STEP_B4: begin
                fringe = 1'b1; a = w_id[3]; b = w_id[1]; c = w_id[7];
            end
            STEP_B5: begin
                fringe = 1'b1; a = w_id[3]; b = w_id[7]; c = w_id[5];
            end
            // close back to the contour's first segment
            STEP_C0: begin
                fringe = 1'b1; a = w_id[6]; b = r_c_lt; c = w_id[4];
            end
            STEP_C1: begin
                fringe = 1'b1; a = w_id[6]; b = r_c_lft; c = r_c_lt;
            end
            STEP_C2: begin
                a = w_id[4]; b = w_id[5]; c = r_c_lb;
            end
            STEP_C3: begin
                a = w_id[4]; b = r_c_lb; c = r_c_lt;
            end
            default: begin
            end
        endcase

        // endpoint +/- offset, saturated
        px = use_next ? r_nx : r_cx;
        py = use_next ? r_ny : r_cy;
        ox = use_fringe ? r_fx : r_bx;
        oy = use_fringe ? r_fy : r_by;
        sx = neg ? (SUM_W'(px) - SUM_W'(ox)) : (SUM_W'(px) + SUM_W'(ox));
        sy = neg ? (SUM_W'(py) - SUM_W'(oy)) : (SUM_W'(py) + SUM_W'(oy));

        w_rec.record_kind = is_vert ? RK_VERTEX : RK_TRIANGLE;
        if (!is_vert) begin
            w_rec.vert_x = '0;
        end else if (sx[SUM_W-1] != sx[SUM_W-2]) begin
            w_rec.vert_x = sx[SUM_W-1] ? COORD_MIN : COORD_MAX;
        end else begin
            w_rec.vert_x = sx[COORD_W-1:0];
        end
        if (!is_vert) begin
            w_rec.vert_y = '0;
        end else if (sy[SUM_W-1] != sy[SUM_W-2]) begin
            w_rec.vert_y = sy[SUM_W-1] ? COORD_MIN : COORD_MAX;
        end else begin
            w_rec.vert_y = sy[COORD_W-1:0];
        end
        w_rec.fringe_flag = fringe;
        w_rec.index_a     = f_out_idx(a);
        w_rec.index_b     = f_out_idx(b);
        w_rec.index_c     = f_out_idx(c);
        w_rec.last_record = w_last_rec;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= 1'b1;
        end else if (o_rec.ready) begin
            r_ov <= 1'b0;
        end
        if (w_adv) begin
            r_out <= w_rec;
        end
    end

    assign o_rec.valid = r_ov;
    assign o_rec.data  = r_out;
endmodule

// ===== rtl/pst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks of the stroke triangulator, bound to the top level.
// ----------------------------------------------------------------------------
module pst_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_seg_ready,
    input  logic          i_rec_valid,
    input  logic          i_rec_ready,
    input  pst_pkg::t_rec i_rec_data
);
    import pst_pkg::*;

    logic w_rec_acc;
    logic w_vert_acc;

    assign w_rec_acc  = i_rec_valid && i_rec_ready;
    assign w_vert_acc = w_rec_acc && (i_rec_data.record_kind == RK_VERTEX);

    // reset leaves the output empty and the input open
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_rec_valid && i_seg_ready))
        else $error("pst: pipeline not empty after reset");

    // a stalled record holds
    a_rec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rec_valid && !i_rec_ready) |=> (i_rec_valid && $stable(i_rec_data)))
        else $error("pst: record changed under stall");

    // back-to-back vertex beats belong to one segment and number upward
    a_vert_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vert_acc && $past(w_vert_acc)) |->
            (i_rec_data.index_a == $past(i_rec_data.index_a) + 16'd1))
        else $error("pst: vertex indices not sequential");

    // vertex records carry no triangle corners and never end a segment
    a_vert_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vert_acc |-> (!i_rec_data.last_record && (i_rec_data.index_b == '0)
                        && (i_rec_data.index_c == '0)))
        else $error("pst: malformed vertex record");
endmodule

bind polyline_stroke_triangulator_top pst_checker u_pst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_seg_ready (i_seg.ready),
    .i_rec_valid (o_rec.valid),
    .i_rec_ready (o_rec.ready),
    .i_rec_data  (o_rec.data)
);
